FILE: design/rcfd_pkg.sv
// Shared types, codes and constants for the RC receiver frame decoder.
package rcfd_pkg;

  // Defaults and fixed geometry.
  localparam int FRAME_BYTES_DEFAULT = 18;
  localparam int DATA_BYTES          = 16;  // leading frame bytes that carry decoded fields
  localparam int QUEUE_DEPTH         = 2;
  localparam int CH_W                = 11;
  localparam int CFG_IDX_W           = 1;

  // Input opcodes.
  localparam logic OP_BYTE = 1'b0;
  localparam logic OP_IDLE = 1'b1;

  // Result status codes.
  localparam logic [1:0] STATUS_OK    = 2'd0;
  localparam logic [1:0] STATUS_RANGE = 2'd1;
  localparam logic [1:0] STATUS_SHORT = 2'd2;

  // Register indexes.
  localparam logic [CFG_IDX_W-1:0] REG_CH_MIN = 1'b0;
  localparam logic [CFG_IDX_W-1:0] REG_CH_MAX = 1'b1;

  localparam logic [CH_W-1:0] CH_MIN_RESET = 11'd364;
  localparam logic [CH_W-1:0] CH_MAX_RESET = 11'd1684;

  typedef struct packed {
    logic       op;
    logic [7:0] rx_byte;
  } in_t;

  typedef struct packed {
    logic        [1:0]      status;
    logic        [CH_W-1:0] stick0;
    logic        [CH_W-1:0] stick1;
    logic        [CH_W-1:0] stick2;
    logic        [CH_W-1:0] stick3;
    logic        [1:0]      switch_left;
    logic        [1:0]      switch_right;
    logic signed [15:0]     mouse_x;
    logic signed [15:0]     mouse_y;
    logic signed [15:0]     mouse_z;
    logic        [15:0]     mouse_buttons;
    logic        [15:0]     key_bits;
  } out_t;

  // One classified frame handed from front to back.
  typedef struct packed {
    logic                           is_short;
    logic [DATA_BYTES-1:0][7:0]     data;
  } job_t;

  // Front-to-queue push beat.
  typedef struct packed {
    logic push;
    job_t job;
  } push_t;

endpackage

FILE: design/rcfd_front.sv
// Front end: byte collection, frame store and frame classification.
module rcfd_front #(
  parameter int FRAME_BYTES = rcfd_pkg::FRAME_BYTES_DEFAULT
) (
  input  logic           clk,
  input  logic           rst,
  input  logic           accept,
  input  rcfd_pkg::in_t  item,
  output rcfd_pkg::push_t push_beat
);

  localparam int CW = $clog2(FRAME_BYTES);

  logic [CW-1:0] byte_count;
  logic [CW-1:0] byte_count_next;
  logic [rcfd_pkg::DATA_BYTES-1:0][7:0] frame_store;
  logic is_byte;
  logic last;

  assign is_byte = (item.op == rcfd_pkg::OP_BYTE);
  assign last    = (byte_count == CW'(FRAME_BYTES - 1));

  always_comb begin
    byte_count_next = byte_count;
    push_beat       = '0;
    // Snapshot merges the incoming byte so a short frame geometry still works.
    for (int i = 0; i < rcfd_pkg::DATA_BYTES; i++) begin
      push_beat.job.data[i] = (is_byte && byte_count == CW'(i)) ? item.rx_byte
                                                                : frame_store[i];
    end
    if (accept) begin
      if (is_byte) begin
        if (last) begin
          byte_count_next        = '0;
          push_beat.push         = 1'b1;
          push_beat.job.is_short = 1'b0;
        end else begin
          byte_count_next = byte_count + 1'b1;
        end
      end else if (byte_count != '0) begin
        byte_count_next        = '0;
        push_beat.push         = 1'b1;
        push_beat.job.is_short = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      byte_count <= '0;
    end else begin
      byte_count <= byte_count_next;
    end
  end

  always_ff @(posedge clk) begin
    for (int i = 0; i < rcfd_pkg::DATA_BYTES; i++) begin
      if (accept && is_byte && byte_count == CW'(i)) begin
        frame_store[i] <= item.rx_byte;
      end
    end
  end

endmodule

FILE: design/rcfd_queue.sv
// Short job queue between front and back ends.
module rcfd_queue (
  input  logic             clk,
  input  logic             rst,
  input  rcfd_pkg::push_t  push_beat,
  input  logic             pop,
  output rcfd_pkg::job_t   head,
  output logic             empty,
  output logic             full
);

  localparam int DEPTH = rcfd_pkg::QUEUE_DEPTH;
  localparam int PW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int NW    = $clog2(DEPTH + 1);

  rcfd_pkg::job_t entries [DEPTH];
  logic [PW-1:0] wr_ptr;
  logic [PW-1:0] rd_ptr;
  logic [NW-1:0] fill;
  logic do_push;
  logic do_pop;

  assign empty   = (fill == '0);
  assign full    = (fill == NW'(DEPTH));
  assign do_push = push_beat.push && !full;
  assign do_pop  = pop && !empty;
  assign head    = entries[rd_ptr];

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      fill   <= '0;
    end else begin
      if (do_push) begin
        wr_ptr <= (wr_ptr == PW'(DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (do_pop) begin
        rd_ptr <= (rd_ptr == PW'(DEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      end
      case ({do_push, do_pop})
        2'b10:   fill <= fill + 1'b1;
        2'b01:   fill <= fill - 1'b1;
        default: fill <= fill;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      entries[wr_ptr] <= push_beat.job;
    end
  end

endmodule

FILE: design/rcfd_back.sv
// Back end: field unpack, range check, frame counters and output register.
module rcfd_back (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              cfg_we,
  input  logic [rcfd_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  logic [rcfd_pkg::CH_W-1:0]         cfg_data,
  input  rcfd_pkg::job_t                    head,
  input  logic                              q_empty,
  output logic                              pop,
  output logic                              fr_valid,
  input  logic                              fr_stall,
  output rcfd_pkg::out_t                    fr_result
);

  logic [rcfd_pkg::CH_W-1:0] channel_min;
  logic [rcfd_pkg::CH_W-1:0] channel_max;
  logic [31:0] good_frames;
  logic [31:0] dropped_frames;
  rcfd_pkg::out_t dec;
  logic [3:0] ch_ok;
  logic all_ok;

  always_comb begin
    dec = '0;
    dec.stick0        = {head.data[1][2:0], head.data[0]};
    dec.stick1        = {head.data[2][5:0], head.data[1][7:3]};
    dec.stick2        = {head.data[4][0], head.data[3], head.data[2][7:6]};
    dec.stick3        = {head.data[5][3:0], head.data[4][7:1]};
    dec.switch_left   = head.data[5][7:6];
    dec.switch_right  = head.data[5][5:4];
    dec.mouse_x       = {head.data[7], head.data[6]};
    dec.mouse_y       = {head.data[9], head.data[8]};
    dec.mouse_z       = {head.data[11], head.data[10]};
    dec.mouse_buttons = {head.data[13], head.data[12]};
    dec.key_bits      = {head.data[15], head.data[14]};

    ch_ok[0] = (dec.stick0 >= channel_min) && (dec.stick0 <= channel_max);
    ch_ok[1] = (dec.stick1 >= channel_min) && (dec.stick1 <= channel_max);
    ch_ok[2] = (dec.stick2 >= channel_min) && (dec.stick2 <= channel_max);
    ch_ok[3] = (dec.stick3 >= channel_min) && (dec.stick3 <= channel_max);
    all_ok   = &ch_ok;

    if (head.is_short) begin
      dec        = '0;
      dec.status = rcfd_pkg::STATUS_SHORT;
    end else begin
      dec.status = all_ok ? rcfd_pkg::STATUS_OK : rcfd_pkg::STATUS_RANGE;
    end
  end

  assign pop = !q_empty && (!fr_valid || !fr_stall);

  always_ff @(posedge clk) begin
    if (rst) begin
      channel_min <= rcfd_pkg::CH_MIN_RESET;
      channel_max <= rcfd_pkg::CH_MAX_RESET;
    end else if (cfg_we) begin
      case (cfg_index)
        rcfd_pkg::REG_CH_MIN: channel_min <= cfg_data;
        rcfd_pkg::REG_CH_MAX: channel_max <= cfg_data;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      fr_valid       <= 1'b0;
      good_frames    <= '0;
      dropped_frames <= '0;
    end else begin
      if (pop) begin
        fr_valid <= 1'b1;
        if (dec.status == rcfd_pkg::STATUS_OK) begin
          good_frames <= good_frames + 32'd1;
        end else begin
          dropped_frames <= dropped_frames + 32'd1;
        end
      end else if (!fr_stall) begin
        fr_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (pop) begin
      fr_result <= dec;
    end
  end

endmodule

FILE: design/rc_receiver_frame_decoder_core.sv
// Top level of the RC receiver frame decoder.
// Takes one beat per cycle on the rx channel: a received byte or a line-idle
// event. Bytes fill a frame of FRAME_BYTES; the last byte of a frame, or an
// idle with a partial frame, yields one result beat on the fr channel
// (front classify, queue, back decode into the output register). An idle
// with no bytes pending yields nothing. Sustained rate is one rx beat per
// cycle; rx_stall rises only when the two-entry job queue is full, which
// happens only if the fr side holds stall. Full frames report four
// 11-bit sticks, two switches, three mouse axes, buttons and key bits, with
// status ok or out-of-range against channel_min/channel_max (inclusive);
// partial frames report status short with all other fields zero.
// Registers: index 0 channel_min (reset 364), index 1 channel_max (reset
// 1684); write only while no frame is in flight.
module rc_receiver_frame_decoder_core #(
  parameter int FRAME_BYTES = rcfd_pkg::FRAME_BYTES_DEFAULT
) (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           rx_valid,
  output logic                           rx_stall,
  input  rcfd_pkg::in_t                  rx_item,
  output logic                           fr_valid,
  input  logic                           fr_stall,
  output rcfd_pkg::out_t                 fr_result,
  input  logic                           cfg_we,
  input  logic [rcfd_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [rcfd_pkg::CH_W-1:0]      cfg_data
);

  rcfd_pkg::push_t push_beat;
  rcfd_pkg::job_t  head;
  logic q_empty;
  logic q_full;
  logic pop;
  logic rx_accept;

  // Stall on a full queue only; stall never looks at the payload.
  assign rx_stall  = q_full;
  assign rx_accept = rx_valid && !rx_stall;

  rcfd_front #(
    .FRAME_BYTES(FRAME_BYTES)
  ) u_front (
    .clk       (clk),
    .rst       (rst),
    .accept    (rx_accept),
    .item      (rx_item),
    .push_beat (push_beat)
  );

  rcfd_queue u_queue (
    .clk       (clk),
    .rst       (rst),
    .push_beat (push_beat),
    .pop       (pop),
    .head      (head),
    .empty     (q_empty),
    .full      (q_full)
  );

  rcfd_back u_back (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .head      (head),
    .q_empty   (q_empty),
    .pop       (pop),
    .fr_valid  (fr_valid),
    .fr_stall  (fr_stall),
    .fr_result (fr_result)
  );

endmodule

FILE: design/rcfd_checker.sv
// Port-level checker for the RC receiver frame decoder, bound to the top level.
module rcfd_checker (
  input logic           clk,
  input logic           rst,
  input logic           fr_valid,
  input logic           fr_stall,
  input rcfd_pkg::out_t fr_result
);

  // No result right after reset.
  a_reset_idle: assert property (@(posedge clk) rst |=> !fr_valid)
    else $error("result beat right after reset");

  // Only defined status codes are produced.
  a_status_code: assert property (@(posedge clk) disable iff (rst)
    fr_valid |-> (fr_result.status == rcfd_pkg::STATUS_OK ||
                  fr_result.status == rcfd_pkg::STATUS_RANGE ||
                  fr_result.status == rcfd_pkg::STATUS_SHORT))
    else $error("undefined status code");

  // Short frames carry zeroed fields.
  a_short_zero: assert property (@(posedge clk) disable iff (rst)
    (fr_valid && fr_result.status == rcfd_pkg::STATUS_SHORT) |->
      (fr_result.stick0 == '0 && fr_result.stick3 == '0 &&
       fr_result.mouse_x == '0 && fr_result.key_bits == '0))
    else $error("short frame with nonzero fields");

  // A stalled result beat holds.
  a_hold: assert property (@(posedge clk) disable iff (rst)
    (fr_valid && fr_stall) |=> (fr_valid && $stable(fr_result)))
    else $error("stalled result beat changed");

endmodule

bind rc_receiver_frame_decoder_core rcfd_checker u_rcfd_checker (.*);

FILE: sim/tb.sv
// Self-checking testbench for the RC receiver frame decoder core.
`timescale 1ns / 1ps

module tb;

  // A stalled beat never finishes on its own. The limit covers the longest
  // stretch of sender gaps and receiver stalls (75% each) with a wide margin.
  localparam int STUCK_LIMIT  = 4000;
  // Front classify, job queue and back decode lie between a byte and its result.
  // Extra wait before a register write so that no frame is still being decoded.
  localparam int DRAIN_CYCLES = 12;
  localparam int NUM_PHASES   = 6;
  localparam int FRAME_LEN    = rcfd_pkg::FRAME_BYTES_DEFAULT;
  localparam int CH_W         = rcfd_pkg::CH_W;

  // How a directed beat is checked: against the predictor, or against a result
  // typed in below.
  typedef enum logic [1:0] {CHK_MODEL, CHK_SHORT, CHK_CORNER} chk_t;

  typedef struct {
    logic       op;
    logic [7:0] data;
    chk_t       chk;
  } dir_row_t;

  typedef struct {
    int lo;
    int hi;
    int idle;
    int stall;
    int budget;
  } phase_t;

  logic clk;
  logic rst;
  logic rx_valid;
  logic rx_stall;
  rcfd_pkg::in_t  rx_item;
  logic fr_valid;
  logic fr_stall;
  rcfd_pkg::out_t fr_result;
  logic                           cfg_we;
  logic [rcfd_pkg::CFG_IDX_W-1:0] cfg_index;
  logic [CH_W-1:0]                cfg_data;

  // Check kind of the beat now on the rx channel; changes only with rx_item.
  chk_t beat_chk;

  // Predictor copy of the block: limits, collected bytes and fill level.
  logic [CH_W-1:0] lim_lo;
  logic [CH_W-1:0] lim_hi;
  logic [7:0]      frame_buf [FRAME_LEN];
  int              fill_cnt;

  rcfd_pkg::out_t pending_frames [$];   // decoded frames still to come out, oldest first
  rcfd_pkg::out_t short_res;
  rcfd_pkg::out_t corner_res;

  int idle_pct;
  int stall_pct;
  int fault_cnt;
  int frame_cnt;
  int stuck_cycles;

  // Directed beats. An idle with nothing collected is ignored; a partial frame
  // ended by idle reports short; then one frame of extreme bytes: all sticks
  // and switches at their top, mouse axes at most negative, most positive and
  // -1, button and key halves split between 00 and FF. Trailing bytes 16 and
  // 17 are collected but decode to nothing.
  dir_row_t dir_rows [23] = '{
    '{rcfd_pkg::OP_IDLE, 8'h00, CHK_MODEL},
    '{rcfd_pkg::OP_BYTE, 8'hFF, CHK_MODEL},
    '{rcfd_pkg::OP_BYTE, 8'h00, CHK_MODEL},
    '{rcfd_pkg::OP_IDLE, 8'hFF, CHK_SHORT},
    '{rcfd_pkg::OP_IDLE, 8'h5A, CHK_MODEL},
    '{rcfd_pkg::OP_BYTE, 8'hFF, CHK_MODEL},
    '{rcfd_pkg::OP_BYTE, 8'hFF, CHK_MODEL},
    '{rcfd_pkg::OP_BYTE, 8'hFF, CHK_MODEL},
    '{rcfd_pkg::OP_BYTE, 8'hFF, CHK_MODEL},
    '{rcfd_pkg::OP_BYTE, 8'hFF, CHK_MODEL},
    '{rcfd_pkg::OP_BYTE, 8'hFF, CHK_MODEL},
    '{rcfd_pkg::OP_BYTE, 8'h00, CHK_MODEL},
    '{rcfd_pkg::OP_BYTE, 8'h80, CHK_MODEL},
    '{rcfd_pkg::OP_BYTE, 8'hFF, CHK_MODEL},
    '{rcfd_pkg::OP_BYTE, 8'h7F, CHK_MODEL},
    '{rcfd_pkg::OP_BYTE, 8'hFF, CHK_MODEL},
    '{rcfd_pkg::OP_BYTE, 8'hFF, CHK_MODEL},
    '{rcfd_pkg::OP_BYTE, 8'h00, CHK_MODEL},
    '{rcfd_pkg::OP_BYTE, 8'hFF, CHK_MODEL},
    '{rcfd_pkg::OP_BYTE, 8'hFF, CHK_MODEL},
    '{rcfd_pkg::OP_BYTE, 8'h00, CHK_MODEL},
    '{rcfd_pkg::OP_BYTE, 8'hA5, CHK_MODEL},
    '{rcfd_pkg::OP_BYTE, 8'h5A, CHK_CORNER}
  };

  // Limit settings per phase, with sender idle and receiver stall rates.
  // Phase 4 limits are drawn at run time.
  phase_t plan [NUM_PHASES] = '{
    '{364,  1684, 0,  0,  250},   // reset values, back to back
    '{0,    2047, 75, 0,  240},   // widest window, sparse sender
    '{2047, 0,    0,  75, 240},   // min above max: nothing passes
    '{1024, 1024, 30, 30, 240},   // single-value window
    '{0,    0,    0,  0,  240},   // random window
    '{200,  1900, 30, 30, 240}
  };

  rc_receiver_frame_decoder_core i_dut (
    .clk       (clk),
    .rst       (rst),
    .rx_valid  (rx_valid),
    .rx_stall  (rx_stall),
    .rx_item   (rx_item),
    .fr_valid  (fr_valid),
    .fr_stall  (fr_stall),
    .fr_result (fr_result),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  function automatic logic in_limits(logic [CH_W-1:0] v);
    return v >= lim_lo && v <= lim_hi;
  endfunction

  // Advance the predictor by one accepted beat. Returns 1 when the beat
  // completes a frame or cuts a partial one short.
  function automatic logic decode_beat(input rcfd_pkg::in_t it,
                                       output rcfd_pkg::out_t res);
    logic [47:0] w;
    res = '0;
    if (it.op == rcfd_pkg::OP_IDLE) begin
      if (fill_cnt == 0) return 1'b0;
      fill_cnt = 0;
      res.status = rcfd_pkg::STATUS_SHORT;
      return 1'b1;
    end
    frame_buf[fill_cnt] = it.rx_byte;
    fill_cnt++;
    if (fill_cnt < FRAME_LEN) return 1'b0;
    fill_cnt = 0;
    // Bytes 0..5 form one little-endian word: four 11-bit sticks, then the
    // right and left switches in the top nibble.
    w = {frame_buf[5], frame_buf[4], frame_buf[3],
         frame_buf[2], frame_buf[1], frame_buf[0]};
    res.stick0        = w[10:0];
    res.stick1        = w[21:11];
    res.stick2        = w[32:22];
    res.stick3        = w[43:33];
    res.switch_right  = w[45:44];
    res.switch_left   = w[47:46];
    res.mouse_x       = {frame_buf[7], frame_buf[6]};
    res.mouse_y       = {frame_buf[9], frame_buf[8]};
    res.mouse_z       = {frame_buf[11], frame_buf[10]};
    res.mouse_buttons = {frame_buf[13], frame_buf[12]};
    res.key_bits      = {frame_buf[15], frame_buf[14]};
    if (in_limits(res.stick0) && in_limits(res.stick1) &&
        in_limits(res.stick2) && in_limits(res.stick3)) begin
      res.status = rcfd_pkg::STATUS_OK;
    end else begin
      res.status = rcfd_pkg::STATUS_RANGE;
    end
    return 1'b1;
  endfunction

  function automatic string show(rcfd_pkg::out_t r);
    return $sformatf({"st=%0d sticks=%0d/%0d/%0d/%0d sw=%0d/%0d",
                      " mouse=%0d/%0d/%0d btn=%h key=%h"},
                     r.status, r.stick0, r.stick1, r.stick2, r.stick3,
                     r.switch_left, r.switch_right, r.mouse_x, r.mouse_y, r.mouse_z,
                     r.mouse_buttons, r.key_bits);
  endfunction

  task automatic note_fault(string msg);
    fault_cnt++;
    if (fault_cnt <= 10) $display("tb: %s", msg);
  endtask

  task automatic compare_frame(rcfd_pkg::out_t want, rcfd_pkg::out_t got);
    string bad;
    bad = "";
    if (got.status        !== want.status)        bad = {bad, " status"};
    if (got.stick0        !== want.stick0)        bad = {bad, " stick0"};
    if (got.stick1        !== want.stick1)        bad = {bad, " stick1"};
    if (got.stick2        !== want.stick2)        bad = {bad, " stick2"};
    if (got.stick3        !== want.stick3)        bad = {bad, " stick3"};
    if (got.switch_left   !== want.switch_left)   bad = {bad, " switch_left"};
    if (got.switch_right  !== want.switch_right)  bad = {bad, " switch_right"};
    if (got.mouse_x       !== want.mouse_x)       bad = {bad, " mouse_x"};
    if (got.mouse_y       !== want.mouse_y)       bad = {bad, " mouse_y"};
    if (got.mouse_z       !== want.mouse_z)       bad = {bad, " mouse_z"};
    if (got.mouse_buttons !== want.mouse_buttons) bad = {bad, " mouse_buttons"};
    if (got.key_bits      !== want.key_bits)      bad = {bad, " key_bits"};
    if (bad != "") begin
      note_fault($sformatf("result %0d wrong in%s: expected %s, got %s",
                           frame_cnt, bad, show(want), show(got)));
    end
  endtask

  // Sampling at the rising edge: predict on every accepted rx beat, then check
  // every accepted result beat against the oldest prediction.
  always @(posedge clk) begin : monitor
    rcfd_pkg::out_t res;
    logic got;
    logic moved;
    if (rst) begin
      stuck_cycles = 0;
    end else begin
      moved = 1'b0;
      if (rx_valid && !rx_stall) begin
        got = decode_beat(rx_item, res);
        case (beat_chk)
          CHK_SHORT:  pending_frames.push_back(short_res);
          CHK_CORNER: pending_frames.push_back(corner_res);
          default: begin
            if (got) pending_frames.push_back(res);
          end
        endcase
        moved = 1'b1;
      end
      if (fr_valid && !fr_stall) begin
        if (pending_frames.size() == 0) begin
          note_fault($sformatf("result %0d with nothing pending: %s", frame_cnt,
                               show(fr_result)));
        end else begin
          compare_frame(pending_frames.pop_front(), fr_result);
        end
        frame_cnt++;
        moved = 1'b1;
      end
      stuck_cycles = moved ? 0 : stuck_cycles + 1;
      if (stuck_cycles >= STUCK_LIMIT) begin
        $display("tb: done, errors");
        $finish;
      end
    end
  end

  // Receiver back-pressure, redrawn every cycle.
  always @(negedge clk) begin
    fr_stall <= !rst && ($urandom_range(0, 99) < stall_pct);
  end

  // One rx beat: optional idle gaps first, then hold the beat until accepted.
  // Called and returns at a falling edge.
  task automatic send_beat(logic op, logic [7:0] data, chk_t chk);
    rcfd_pkg::in_t it;
    it.op      = op;
    it.rx_byte = data;
    while ($urandom_range(0, 99) < idle_pct) begin
      rx_valid <= 1'b0;
      @(negedge clk);
    end
    rx_valid <= 1'b1;
    rx_item  <= it;
    beat_chk <= chk;
    do @(posedge clk); while (!(rx_valid && !rx_stall));
    @(negedge clk);
  endtask

  // Sender holds off until every frame in flight has come out.
  task automatic drain_results();
    rx_valid <= 1'b0;
    while (pending_frames.size() != 0) @(negedge clk);
    repeat (DRAIN_CYCLES) @(negedge clk);
  endtask

  // Write both limits on back-to-back cycles; only while drained.
  task automatic set_limits(logic [CH_W-1:0] lo, logic [CH_W-1:0] hi);
    cfg_we    <= 1'b1;
    cfg_index <= rcfd_pkg::REG_CH_MIN;
    cfg_data  <= lo;
    @(posedge clk);
    lim_lo = lo;
    @(negedge clk);
    cfg_index <= rcfd_pkg::REG_CH_MAX;
    cfg_data  <= hi;
    @(posedge clk);
    lim_hi = hi;
    @(negedge clk);
    cfg_we <= 1'b0;
  endtask

  // Data bytes lean toward the zero, all-ones and sign corners a quarter of the time.
  function automatic logic [7:0] rand_byte();
    if ($urandom_range(0, 3) != 0) return 8'($urandom_range(0, 255));
    case ($urandom_range(0, 3))
      0:       return 8'h00;
      1:       return 8'hFF;
      2:       return 8'h80;
      default: return 8'h7F;
    endcase
  endfunction

  // Mostly inside the current window so that good frames are common, with
  // the window bounds and their outer neighbors mixed in.
  function automatic logic [CH_W-1:0] pick_stick();
    int r;
    r = $urandom_range(0, 9);
    if (r < 7 && lim_lo <= lim_hi) return CH_W'($urandom_range(lim_lo, lim_hi));
    if (r == 7) return $urandom_range(0, 1) ? lim_lo : lim_lo - 1'b1;
    if (r == 8) return $urandom_range(0, 1) ? lim_hi : lim_hi + 1'b1;
    return CH_W'($urandom_range(0, 2047));
  endfunction

  task automatic send_frame();
    logic [47:0] w;
    logic [1:0]  sw_l;
    logic [1:0]  sw_r;
    sw_l = 2'($urandom_range(0, 3));
    sw_r = 2'($urandom_range(0, 3));
    w = {sw_l, sw_r, pick_stick(), pick_stick(), pick_stick(), pick_stick()};
    for (int i = 0; i < 6; i++) send_beat(rcfd_pkg::OP_BYTE, w[8*i +: 8], CHK_MODEL);
    for (int i = 6; i < FRAME_LEN; i++) begin
      send_beat(rcfd_pkg::OP_BYTE, rand_byte(), CHK_MODEL);
    end
  endtask

  // Mostly whole frames, often followed by a line idle; the rest is frames cut
  // short by idle, lone bytes that shift framing, and stray idles. Stray idles
  // do not count against the budget.
  task automatic run_traffic(int budget);
    int sent;
    int r;
    int n;
    sent = 0;
    while (sent < budget) begin
      r = $urandom_range(0, 19);
      if (r < 14) begin
        send_frame();
        sent += FRAME_LEN;
        if ($urandom_range(0, 1)) send_beat(rcfd_pkg::OP_IDLE, rand_byte(), CHK_MODEL);
      end else if (r < 17) begin
        n = $urandom_range(1, FRAME_LEN - 1);
        repeat (n) send_beat(rcfd_pkg::OP_BYTE, rand_byte(), CHK_MODEL);
        send_beat(rcfd_pkg::OP_IDLE, rand_byte(), CHK_MODEL);
        sent += n + 1;
      end else if (r == 17) begin
        send_beat(rcfd_pkg::OP_BYTE, rand_byte(), CHK_MODEL);
        sent++;
      end else begin
        send_beat(rcfd_pkg::OP_IDLE, rand_byte(), CHK_MODEL);
      end
    end
  endtask

  initial begin : stimulus
    rst       = 1'b1;
    rx_valid  = 1'b0;
    rx_item   = '0;
    beat_chk  = CHK_MODEL;
    fr_stall  = 1'b0;
    cfg_we    = 1'b0;
    cfg_index = rcfd_pkg::REG_CH_MIN;
    cfg_data  = '0;
    idle_pct  = 0;
    stall_pct = 0;
    fault_cnt = 0;
    frame_cnt = 0;
    lim_lo    = rcfd_pkg::CH_MIN_RESET;
    lim_hi    = rcfd_pkg::CH_MAX_RESET;
    fill_cnt  = 0;
    foreach (frame_buf[i]) frame_buf[i] = '0;

    short_res        = '0;
    short_res.status = rcfd_pkg::STATUS_SHORT;

    corner_res               = '0;
    corner_res.status        = rcfd_pkg::STATUS_RANGE;
    corner_res.stick0        = 11'h7FF;
    corner_res.stick1        = 11'h7FF;
    corner_res.stick2        = 11'h7FF;
    corner_res.stick3        = 11'h7FF;
    corner_res.switch_left   = 2'd3;
    corner_res.switch_right  = 2'd3;
    corner_res.mouse_x       = 16'sh8000;
    corner_res.mouse_y       = 16'sh7FFF;
    corner_res.mouse_z       = 16'shFFFF;
    corner_res.mouse_buttons = 16'hFF00;
    corner_res.key_bits      = 16'h00FF;

    plan[4].lo = $urandom_range(0, 1023);
    plan[4].hi = $urandom_range(1024, 2047);

    repeat (6) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    // Directed beats run with the reset limits and no idling.
    foreach (dir_rows[k]) send_beat(dir_rows[k].op, dir_rows[k].data, dir_rows[k].chk);

    for (int p = 0; p < NUM_PHASES; p++) begin
      drain_results();
      set_limits(CH_W'(plan[p].lo), CH_W'(plan[p].hi));
      idle_pct  = plan[p].idle;
      stall_pct = plan[p].stall;
      run_traffic(plan[p].budget);
    end

    drain_results();
    if (fault_cnt == 0) begin
      $display("tb: done, clean");
    end else begin
      $display("tb: done, errors");
    end
    $finish;
  end

endmodule
